@@ rtl/zz_scan_pkg.sv @@
// Shared widths, reset values and register map for the zigzag scan address generator.
package zz_scan_pkg;

  // Fixed field widths of the word interfaces
  localparam int SIDE_W      = 7;
  localparam int SEQ_W       = 12;
  localparam int OUT_COORD_W = 6;
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 3;

  // Register map (register index taken from the word address)
  localparam logic REG_SIDE_LENGTH = 1'b0;

  // Side length after reset
  localparam logic [SIDE_W-1:0] SIDE_RESET = 7'd8;

endpackage

@@ rtl/zz_scan_step.sv @@
// Next-position logic of the zigzag scan: picks the cell to emit and the one after it.
module zz_scan_step import zz_scan_pkg::*; #(
  parameter int CW    = 6,
  parameter int SIDEW = 7
) (
  input  logic [SIDEW-1:0] side_eff,
  input  logic             restart,
  input  logic [CW-1:0]    cur_row,
  input  logic [CW-1:0]    cur_col,
  input  logic             cur_up,
  input  logic [SEQ_W-1:0] cur_seq,
  output logic [CW-1:0]    emit_row,
  output logic [CW-1:0]    emit_col,
  output logic [SEQ_W-1:0] emit_seq,
  output logic             emit_last,
  output logic [CW-1:0]    row_nxt,
  output logic [CW-1:0]    col_nxt,
  output logic             up_nxt,
  output logic [SEQ_W-1:0] seq_nxt
);

  logic          go_origin;
  logic          up_cur;
  logic [CW-1:0] top;
  logic          n_even;
  logic          y_even;
  logic          x_even;

  // Fall back to the origin on restart or when the position left the matrix
  always_comb begin
    go_origin = restart
              || (SIDEW'(cur_row) >= side_eff)
              || (SIDEW'(cur_col) >= side_eff);
    emit_row  = go_origin ? '0 : cur_row;
    emit_col  = go_origin ? '0 : cur_col;
    emit_seq  = go_origin ? '0 : cur_seq;
    up_cur    = go_origin ? 1'b0 : cur_up;
    top       = CW'(side_eff - SIDEW'(1));
    emit_last = (emit_row == top) && (emit_col == top);
  end

  assign n_even = ~side_eff[0];
  assign y_even = ~emit_row[0];
  assign x_even = ~emit_col[0];

  // Advance one cell along the zigzag, or wrap after the final cell
  always_comb begin
    row_nxt = emit_row;
    col_nxt = emit_col;
    up_nxt  = up_cur;
    seq_nxt = emit_seq + SEQ_W'(1);
    if (emit_last) begin
      row_nxt = '0;
      col_nxt = '0;
      up_nxt  = 1'b0;
      seq_nxt = '0;
    end else if (emit_col == '0 && emit_row == top) begin
      // bottom-left corner
      col_nxt = emit_col + CW'(1);
      if (n_even) begin
        row_nxt = emit_row - CW'(1);
        up_nxt  = 1'b1;
      end
    end else if (emit_col == top && emit_row == '0) begin
      // top-right corner
      row_nxt = emit_row + CW'(1);
      if (!n_even) begin
        col_nxt = emit_col - CW'(1);
        up_nxt  = 1'b0;
      end
    end else if (emit_col == '0) begin
      // left edge
      if (y_even) begin
        row_nxt = emit_row + CW'(1);
        up_nxt  = 1'b1;
      end else begin
        row_nxt = emit_row - CW'(1);
        col_nxt = emit_col + CW'(1);
      end
    end else if (emit_col == top) begin
      // right edge
      row_nxt = emit_row + CW'(1);
      if (n_even != y_even) begin
        col_nxt = emit_col - CW'(1);
        up_nxt  = 1'b0;
      end
    end else if (emit_row == '0) begin
      // top edge
      if (x_even) begin
        row_nxt = emit_row + CW'(1);
        col_nxt = emit_col - CW'(1);
        up_nxt  = 1'b0;
      end else begin
        col_nxt = emit_col + CW'(1);
      end
    end else if (emit_row == top) begin
      // bottom edge
      col_nxt = emit_col + CW'(1);
      if (n_even == x_even) begin
        row_nxt = emit_row - CW'(1);
        up_nxt  = 1'b1;
      end
    end else if (up_cur) begin
      row_nxt = emit_row - CW'(1);
      col_nxt = emit_col + CW'(1);
    end else begin
      row_nxt = emit_row + CW'(1);
      col_nxt = emit_col - CW'(1);
    end
  end

endmodule

@@ rtl/zigzag_scan_address_generator.sv @@
// The result word is registered: it is valid in the cycle after its input word is accepted.
// Throughput: one word per cycle while out_ready is high; the next-position logic is
// combinational around the position registers, and the output register frees as it is read.
// Reset: synchronous active-low rst_n puts the scan at the origin, index zero,
// side_length to 8, and empties the output register.
// Top level of the zigzag scan address generator.
module zigzag_scan_address_generator import zz_scan_pkg::*; #(
  parameter int MAX_SIDE = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input word channel
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_restart,
  // result word channel
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [OUT_COORD_W-1:0] out_row,
  output logic [OUT_COORD_W-1:0] out_column,
  output logic [SEQ_W-1:0]       out_order_index,
  output logic                   out_last,
  // configuration port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_ADDR_W-1:0]  paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready
);

  localparam int CW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int SIDEW = $clog2(MAX_SIDE + 1);
  localparam int CMPW  = (SIDEW > SIDE_W) ? SIDEW : SIDE_W;

  logic [SIDE_W-1:0]      side_r;
  logic [CMPW-1:0]        side_ext;
  logic [SIDEW-1:0]       side_eff;

  logic [CW-1:0]          row_r;
  logic [CW-1:0]          col_r;
  logic                   up_r;
  logic [SEQ_W-1:0]       seq_r;

  logic [CW-1:0]          emit_row;
  logic [CW-1:0]          emit_col;
  logic [SEQ_W-1:0]       emit_seq;
  logic                   emit_last;
  logic [CW-1:0]          row_nxt;
  logic [CW-1:0]          col_nxt;
  logic                   up_nxt;
  logic [SEQ_W-1:0]       seq_nxt;

  logic                   out_valid_r;
  logic [OUT_COORD_W-1:0] out_row_r;
  logic [OUT_COORD_W-1:0] out_col_r;
  logic [SEQ_W-1:0]       out_seq_r;
  logic                   out_last_r;

  logic                   in_fire;
  logic                   cfg_wr;

  // Configuration register write and read
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_SIDE_LENGTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= SIDE_RESET;
    end else if (cfg_wr) begin
      side_r <= pwdata[SIDE_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_SIDE_LENGTH) ? APB_DATA_W'(side_r) : '0;

  // Clamp the side length to 1..MAX_SIDE
  always_comb begin
    side_ext = CMPW'(side_r);
    if (side_ext == '0) begin
      side_eff = SIDEW'(1);
    end else if (side_ext > CMPW'(MAX_SIDE)) begin
      side_eff = SIDEW'(MAX_SIDE);
    end else begin
      side_eff = SIDEW'(side_ext);
    end
  end

  zz_scan_step #(
    .CW    (CW),
    .SIDEW (SIDEW)
  ) u_step (
    .side_eff  (side_eff),
    .restart   (in_restart),
    .cur_row   (row_r),
    .cur_col   (col_r),
    .cur_up    (up_r),
    .cur_seq   (seq_r),
    .emit_row  (emit_row),
    .emit_col  (emit_col),
    .emit_seq  (emit_seq),
    .emit_last (emit_last),
    .row_nxt   (row_nxt),
    .col_nxt   (col_nxt),
    .up_nxt    (up_nxt),
    .seq_nxt   (seq_nxt)
  );

  // Take a word whenever the output register is empty or being drained
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Advance the scan position on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
      up_r  <= 1'b0;
      seq_r <= '0;
    end else if (in_fire) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
      up_r  <= up_nxt;
      seq_r <= seq_nxt;
    end
  end

  // Output register: hold the result word until it is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_row_r  <= OUT_COORD_W'(emit_row);
      out_col_r  <= OUT_COORD_W'(emit_col);
      out_seq_r  <= emit_seq;
      out_last_r <= emit_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_row         = out_row_r;
  assign out_column      = out_col_r;
  assign out_order_index = out_seq_r;
  assign out_last        = out_last_r;

  // The final cell sits on the diagonal
  a_last_diag : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (out_row_r == out_col_r))
    else $error("last word off the diagonal");

  // After the final cell the scan wraps to the origin
  a_wrap : assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && emit_last) |=> (row_r == '0 && col_r == '0 && seq_r == '0 && !up_r))
    else $error("scan did not wrap after the final cell");

  // Otherwise the index advances by one over the emitted word
  a_index_step : assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !emit_last) |=> (seq_r == $past(emit_seq) + SEQ_W'(1)))
    else $error("sequence index did not advance by one");

  // An emitted word carries the index of the accepted word
  a_out_index : assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (out_valid_r && out_seq_r == $past(emit_seq)))
    else $error("result word does not match the accepted word");

endmodule

@@ test/zigzag_scan_address_generator_tb.sv @@
// Self-checking testbench for the zigzag scan address generator.
`timescale 1ns / 1ps

module zigzag_scan_address_generator_tb;
  import zz_scan_pkg::*;

  localparam int TB_MAX_SIDE = 64;
  localparam logic [APB_ADDR_W-1:0] SIDE_ADDR = APB_ADDR_W'(4 * REG_SIDE_LENGTH);
  localparam int RANDOM_WORDS = 1100;

  // Expected cells of the scan and the scan position they are derived from
  class zz_scoreboard;
    typedef struct {
      logic [OUT_COORD_W-1:0] row;
      logic [OUT_COORD_W-1:0] column;
      logic [SEQ_W-1:0]       order_index;
      logic                   last;
    } cell_t;

    cell_t                  expected_cells[$];
    logic [SIDE_W-1:0]      side_reg;
    logic [OUT_COORD_W-1:0] row_pos;
    logic [OUT_COORD_W-1:0] col_pos;
    bit                     going_up;
    logic [SEQ_W-1:0]       seq_pos;
    int                     mismatches;

    function new();
      side_reg   = SIDE_RESET;
      mismatches = 0;
      go_origin();
    endfunction

    function void go_origin();
      row_pos  = '0;
      col_pos  = '0;
      going_up = 1'b0;
      seq_pos  = '0;
    endfunction

    function void set_side(logic [SIDE_W-1:0] value);
      side_reg = value;
    endfunction

    function int eff_side();
      if (side_reg == 0) return 1;
      if (side_reg > TB_MAX_SIDE) return TB_MAX_SIDE;
      return int'(side_reg);
    endfunction

    // Move one cell along the zigzag; edges and corners follow parity rules
    function void step_cell(int n);
      int y, x, top;
      bit n_even, y_even, x_even;
      y = int'(row_pos);
      x = int'(col_pos);
      top = n - 1;
      n_even = (n % 2) == 0;
      y_even = (y % 2) == 0;
      x_even = (x % 2) == 0;
      if (x == 0 && y == top) begin
        if (n_even) begin
          y--; x++; going_up = 1'b1;
        end else begin
          x++;
        end
      end else if (x == top && y == 0) begin
        if (n_even) begin
          y++;
        end else begin
          y++; x--; going_up = 1'b0;
        end
      end else if (x == 0) begin
        if (y_even) begin
          y++; going_up = 1'b1;
        end else begin
          y--; x++;
        end
      end else if (x == top) begin
        if (n_even == y_even) begin
          y++;
        end else begin
          y++; x--; going_up = 1'b0;
        end
      end else if (y == 0) begin
        if (x_even) begin
          y++; x--; going_up = 1'b0;
        end else begin
          x++;
        end
      end else if (y == top) begin
        if (n_even == x_even) begin
          x++; y--; going_up = 1'b1;
        end else begin
          x++;
        end
      end else if (going_up) begin
        y--; x++;
      end else begin
        y++; x--;
      end
      row_pos = y[OUT_COORD_W-1:0];
      col_pos = x[OUT_COORD_W-1:0];
    endfunction

    // Record the cell that an accepted input word must produce
    function void note_input(bit restart);
      int n;
      cell_t c;
      n = eff_side();
      if (restart || row_pos >= n || col_pos >= n) go_origin();
      c.row         = row_pos;
      c.column      = col_pos;
      c.order_index = seq_pos;
      c.last        = (row_pos == n - 1) && (col_pos == n - 1);
      expected_cells.push_back(c);
      if (c.last) begin
        go_origin();
      end else begin
        step_cell(n);
        seq_pos = seq_pos + 1'b1;
      end
    endfunction

    // Compare a result word against the oldest expected cell
    function void check_result(logic [OUT_COORD_W-1:0] row, logic [OUT_COORD_W-1:0] column,
                               logic [SEQ_W-1:0] order_index, logic last);
      cell_t c;
      if (expected_cells.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: row %0d column %0d index %0d last %0b",
                   row, column, order_index, last);
        return;
      end
      c = expected_cells.pop_front();
      if (row !== c.row || column !== c.column || order_index !== c.order_index ||
          last !== c.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $write("result mismatch: expected row %0d column %0d index %0d last %0b, ",
                 c.row, c.column, c.order_index, c.last);
          $display("got row %0d column %0d index %0d last %0b",
                   row, column, order_index, last);
        end
      end
    endfunction

    function int pending();
      return expected_cells.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic in_restart;
  logic out_valid;
  logic out_ready;
  logic [OUT_COORD_W-1:0] out_row;
  logic [OUT_COORD_W-1:0] out_column;
  logic [SEQ_W-1:0]       out_order_index;
  logic                   out_last;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [APB_ADDR_W-1:0]  paddr;
  logic [APB_DATA_W-1:0]  pwdata;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;

  zz_scoreboard scan_board;
  int send_idle_pct;
  int recv_idle_pct;

  zigzag_scan_address_generator #(
    .MAX_SIDE(TB_MAX_SIDE)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_restart(in_restart),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_row(out_row),
    .out_column(out_column),
    .out_order_index(out_order_index),
    .out_last(out_last),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Take result words and stall the output channel at random
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      scan_board.check_result(out_row, out_column, out_order_index, out_last);
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Send one input word after a random gap, then hold it until accepted
  task automatic send_word(bit restart);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (!in_ready);
    scan_board.note_input(restart);
  endtask

  // Drop valid and wait until every expected result word has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (scan_board.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Write side_length while the block is idle
  task automatic write_side(logic [SIDE_W-1:0] value);
    drain_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SIDE_ADDR;
    pwdata  <= {$urandom} & ~{{(APB_DATA_W-SIDE_W){1'b0}}, {SIDE_W{1'b1}}} | value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    scan_board.set_side(value);
  endtask

  function automatic logic [SIDE_W-1:0] pick_side();
    int r;
    r = $urandom_range(99);
    if (r < 55) return SIDE_W'($urandom_range(6, 1));
    if (r < 80) return SIDE_W'($urandom_range(16, 7));
    if (r < 90) return SIDE_W'($urandom_range(64, 17));
    if (r < 95) return '0;
    return SIDE_W'($urandom_range(127, 65));
  endfunction

  initial begin
    int sent;
    int phase_len;
    int restart_pct;
    int phase_no;
    scan_board    = new();
    send_idle_pct = 18;
    recv_idle_pct = 82;
    clk        = 1'b0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_restart = 1'b0;
    out_ready  = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset side length of eight, restart on the first word
    send_word(1'b1);
    send_word(1'b0);
    send_word(1'b0);
    // Full two by two scan and the wrap to the origin
    write_side(7'd2);
    send_word(1'b1);
    repeat (5) send_word(1'b0);
    // One cell matrix, side length zero and a saturated side length
    write_side(7'd1);
    repeat (2) send_word(1'b0);
    write_side(7'd0);
    repeat (2) send_word(1'b0);
    write_side(7'd127);
    repeat (2) send_word(1'b0);
    // Odd side, then shrink so the position falls outside, then grow mid-scan
    write_side(7'd3);
    send_word(1'b1);
    repeat (4) send_word(1'b0);
    write_side(7'd2);
    send_word(1'b0);
    write_side(7'd5);
    repeat (2) send_word(1'b0);

    // Random phases: mostly clean scans, some noisy with frequent restarts
    sent = 0;
    phase_no = 0;
    while (sent < RANDOM_WORDS) begin
      if (sent < RANDOM_WORDS / 3) begin
        send_idle_pct = 18;
        recv_idle_pct = 82;
      end else if (sent < 2 * RANDOM_WORDS / 3) begin
        send_idle_pct = 82;
        recv_idle_pct = 18;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_side(phase_no == 0 ? 7'd64 : pick_side());
      restart_pct = ($urandom_range(99) < 80) ? 2 : 30;
      phase_len = $urandom_range(80, 20);
      repeat (phase_len) begin
        send_word($urandom_range(99) < restart_pct);
        sent++;
      end
      phase_no++;
    end

    // Wait out the last result words
    drain_results();
    repeat (8) @(posedge clk);
    if (scan_board.mismatches == 0 && scan_board.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
